@@ sv/psgtn_pkg.sv @@
`default_nettype none
package psgtn_pkg;

    localparam int SPAN    = 65536;
    localparam int SPAN_SH = 16;
    localparam int FULL    = 32767;

    localparam int CNT_W  = 34;
    localparam int HP_W   = 32;
    localparam int HI_W   = 18;
    localparam int LVL_W  = 13;
    localparam int MA_W   = 21;
    localparam int MB_W   = 16;
    localparam int PROD_W = 38;
    localparam int SUM_W  = 33;
    localparam int MIX_W  = 15;

    localparam logic [2:0] CFG_UPDATE_STEP   = 3'd0;
    localparam logic [2:0] CFG_FEEDBACK_MASK = 3'd1;
    localparam logic [2:0] CFG_NOISE_TAPS    = 3'd2;
    localparam logic [2:0] CFG_NOISE_INVERT  = 3'd3;
    localparam logic [2:0] CFG_ROUTE_LEFT    = 3'd4;
    localparam logic [2:0] CFG_ROUTE_RIGHT   = 3'd5;
    localparam logic [2:0] CFG_OUT_GAIN      = 3'd6;

    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_STEREO = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    localparam logic [19:0] RST_STEP   = 20'd12838;
    localparam logic [15:0] RST_FBMASK = 16'h4000;
    localparam logic [15:0] RST_TAPS   = 16'h0003;
    localparam logic [15:0] RST_GAIN   = 16'd256;

    localparam logic [2:0] REG_NOISE = 3'd6;
    localparam logic [2:0] REG_TONE2 = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WR, ST_WR_MUL, ST_T_INIT, ST_T_A, ST_T_B, ST_T_END,
        ST_N1, ST_N2, ST_MIX_M, ST_MIX_A, ST_G_L, ST_G_LA, ST_G_RA, ST_OUT
    } state_t;

    // 2 dB per step attenuation levels, quarter full scale at step 0
    function automatic logic [LVL_W-1:0] level_lut(input logic [3:0] att);
        logic [LVL_W-1:0] r;
        case (att)
            4'd0:    r = 13'd8191;
            4'd1:    r = 13'd6506;
            4'd2:    r = 13'd5168;
            4'd3:    r = 13'd4105;
            4'd4:    r = 13'd3260;
            4'd5:    r = 13'd2590;
            4'd6:    r = 13'd2057;
            4'd7:    r = 13'd1634;
            4'd8:    r = 13'd1298;
            4'd9:    r = 13'd1031;
            4'd10:   r = 13'd819;
            4'd11:   r = 13'd650;
            4'd12:   r = 13'd516;
            4'd13:   r = 13'd410;
            4'd14:   r = 13'd326;
            default: r = 13'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/psgtn_mul.sv @@
`default_nettype none
module psgtn_mul
    import psgtn_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic signed [MA_W-1:0]   mul_a,
    input  wire logic        [MB_W-1:0]   mul_b,
    output logic signed      [PROD_W-1:0] prod_reg
);

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(mul_a * $signed({1'b0, mul_b}));

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule
`default_nettype wire

@@ sv/psg_tone_noise_generator_core.sv @@
`default_nettype none
// Three-tone plus noise sound generator. A write byte passes through ST_WR, and for a
// tone period also ST_WR_MUL; a stereo mask write is taken directly in ST_IDLE. A
// sample tick runs each channel's edge loop in turn: each tone goes through ST_T_INIT,
// ST_T_A and ST_T_END, with an ST_T_B and ST_T_A pair for every further pair of half
// periods ending in the span. The noise channel makes one ST_N1/ST_N2 pass per noise
// register step in the span, and one more for the span end unless a step lands
// exactly on it. Then come mixing (ST_MIX_M, ST_MIX_A per channel) and gain (ST_G_L,
// ST_G_LA, ST_G_RA) on a single shared multiplier, and ST_OUT hands off the result
// once any earlier result has been taken. Very short periods make ticks proportionally
// longer. s_axis_tready is high only between items; configuration is always ready.
module psg_tone_noise_generator_core
    import psgtn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    localparam logic signed [SUM_W-1:0] MIX_MAX = SUM_W'(FULL * SPAN);
    localparam logic [MIX_W-1:0]        SAT     = MIX_W'(FULL);

    logic [19:0] step_reg;
    logic [15:0] fbm_reg, taps_reg, gain_reg;
    logic        inv_reg, rtl_reg, rtr_reg;

    state_t state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic [7:0] d_reg, d_next;
    logic [2:0] wr_r_reg, wr_r_next;
    logic [9:0] tone_reg [8];
    logic [9:0] tone_next [8];
    logic [2:0] latch_reg, latch_next;
    logic [LVL_W-1:0] lvl_reg [4];
    logic [LVL_W-1:0] lvl_next [4];
    logic [15:0] shift_reg, shift_next;
    logic white_reg, white_next;
    logic [HP_W-1:0] hp_reg [4];
    logic [HP_W-1:0] hp_next [4];
    logic signed [CNT_W-1:0] dc_reg [4];
    logic signed [CNT_W-1:0] dc_next [4];
    logic [3:0] out_reg, out_next;
    logic [7:0] stereo_reg, stereo_next;
    logic signed [HI_W-1:0] hi_reg [4];
    logic signed [HI_W-1:0] hi_next [4];
    logic signed [CNT_W-1:0] cnt_reg, cnt_next, v_reg, v_next;
    logic [16:0] left_reg, left_next;
    logic signed [SUM_W-1:0] sl_reg, sl_next, sr_reg, sr_next;
    logic [MIX_W-1:0] gl_reg, gl_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic signed [MA_W-1:0]   mul_a;
    logic        [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_reg;

    logic [19:0] step_eff;
    logic        s_fire;
    logic [2:0]  r_w;
    logic [1:0]  c_w;
    logic [9:0]  t_new;
    logic [HP_W-1:0] hp_p;
    logic signed [CNT_W-1:0] per, c1, nxt, span_c;
    logic        fb, adv, o_new;
    logic [15:0] ns;
    logic [MIX_W-1:0] lm, rm, gsat;

    assign step_eff      = (step_reg == 20'd0) ? 20'd1 : step_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign span_c        = CNT_W'(SPAN);

    psgtn_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= RST_STEP;
            fbm_reg  <= RST_FBMASK;
            taps_reg <= RST_TAPS;
            inv_reg  <= 1'b1;
            rtl_reg  <= 1'b1;
            rtr_reg  <= 1'b1;
            gain_reg <= RST_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_UPDATE_STEP:   step_reg <= cfg_data;
                CFG_FEEDBACK_MASK: fbm_reg  <= cfg_data[15:0];
                CFG_NOISE_TAPS:    taps_reg <= cfg_data[15:0];
                CFG_NOISE_INVERT:  inv_reg  <= cfg_data[0];
                CFG_ROUTE_LEFT:    rtl_reg  <= cfg_data[0];
                CFG_ROUTE_RIGHT:   rtr_reg  <= cfg_data[0];
                CFG_OUT_GAIN:      gain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // clamp of the mix sums, and gain clip of the current product
    always_comb begin
        if (sl_reg < 0)            lm = '0;
        else if (sl_reg > MIX_MAX) lm = SAT;
        else                       lm = sl_reg[SPAN_SH +: MIX_W];
        if (sr_reg < 0)            rm = '0;
        else if (sr_reg > MIX_MAX) rm = SAT;
        else                       rm = sr_reg[SPAN_SH +: MIX_W];
        if (prod_reg[PROD_W-1:8+MIX_W] != '0) gsat = SAT;
        else                                 gsat = prod_reg[8 +: MIX_W];
    end

    always_comb begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        d_next       = d_reg;
        wr_r_next    = wr_r_reg;
        tone_next    = tone_reg;
        latch_next   = latch_reg;
        lvl_next     = lvl_reg;
        shift_next   = shift_reg;
        white_next   = white_reg;
        hp_next      = hp_reg;
        dc_next      = dc_reg;
        out_next     = out_reg;
        stereo_next  = stereo_reg;
        hi_next      = hi_reg;
        cnt_next     = cnt_reg;
        v_next       = v_reg;
        left_next    = left_reg;
        sl_next      = sl_reg;
        sr_next      = sr_reg;
        gl_next      = gl_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        mul_a        = '0;
        mul_b        = '0;

        r_w   = d_reg[7] ? d_reg[6:4] : latch_reg;
        c_w   = r_w[2:1];
        t_new = {tone_reg[r_w][9:4], d_reg[3:0]};
        if (!d_reg[7] && !r_w[0] && r_w != REG_NOISE) begin
            t_new = {d_reg[5:0], tone_reg[r_w][3:0]};
        end
        hp_p = (prod_reg[HP_W-1:0] == '0) ? HP_W'(step_eff) : prod_reg[HP_W-1:0];
        per  = CNT_W'(hp_reg[ch_reg]);
        c1   = cnt_reg + per;
        nxt  = (cnt_reg < $signed({17'd0, left_reg})) ? cnt_reg
                                                      : $signed({17'd0, left_reg});
        adv  = (cnt_reg <= 0);
        fb   = white_reg ? ^(shift_reg & taps_reg) : shift_reg[0];
        ns   = {1'b0, shift_reg[15:1]} | (fb ? fbm_reg : 16'd0);
        o_new = adv ? (white_reg ? (ns[0] ^ inv_reg) : ns[0]) : out_reg[3];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    d_next = s_axis_tdata;
                    case (s_axis_tuser)
                        FUNC_WRITE:  state_next = ST_WR;
                        FUNC_STEREO: stereo_next = s_axis_tdata;
                        FUNC_TICK: begin
                            ch_next    = 2'd0;
                            state_next = ST_T_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WR: begin
                latch_next     = r_w;
                wr_r_next      = r_w;
                tone_next[r_w] = t_new;
                state_next     = ST_IDLE;
                if (!r_w[0] && r_w != REG_NOISE) begin
                    mul_a      = MA_W'({1'b0, step_eff});
                    mul_b      = MB_W'(t_new);
                    state_next = ST_WR_MUL;
                end else if (r_w == REG_NOISE) begin
                    white_next = t_new[2];
                    if (t_new[1:0] == 2'd3) hp_next[3] = {hp_reg[2][HP_W-2:0], 1'b0};
                    else hp_next[3] = HP_W'(step_eff) << (3'd5 + {1'b0, t_new[1:0]});
                    shift_next  = fbm_reg;
                    out_next[3] = fbm_reg[0];
                end else begin
                    lvl_next[c_w] = level_lut(d_reg[3:0]);
                end
            end
            ST_WR_MUL: begin
                hp_next[wr_r_reg[2:1]] = hp_p;
                if (wr_r_reg == REG_TONE2 && tone_reg[REG_NOISE][1:0] == 2'd3) begin
                    hp_next[3] = {hp_p[HP_W-2:0], 1'b0};
                end
                state_next = ST_IDLE;
            end
            ST_T_INIT: begin
                v_next     = out_reg[ch_reg] ? dc_reg[ch_reg] : '0;
                cnt_next   = dc_reg[ch_reg] - span_c;
                state_next = ST_T_A;
            end
            ST_T_A: begin
                if (cnt_reg > 0) begin
                    state_next = ST_T_END;
                end else begin
                    cnt_next = c1;
                    if (c1 > 0) begin
                        out_next[ch_reg] = !out_reg[ch_reg];
                        if (!out_reg[ch_reg]) v_next = v_reg + per;
                        state_next = ST_T_END;
                    end else begin
                        state_next = ST_T_B;
                    end
                end
            end
            ST_T_B: begin
                cnt_next   = c1;
                v_next     = v_reg + per;
                state_next = ST_T_A;
            end
            ST_T_END: begin
                dc_next[ch_reg] = cnt_reg;
                hi_next[ch_reg] = HI_W'(out_reg[ch_reg] ? (v_reg - cnt_reg) : v_reg);
                if (ch_reg == 2'd2) begin
                    cnt_next   = dc_reg[3];
                    left_next  = 17'(SPAN);
                    v_next     = '0;
                    state_next = ST_N1;
                end else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_T_INIT;
                end
            end
            ST_N1: begin
                if (out_reg[3]) v_next = v_reg + cnt_reg;
                cnt_next   = cnt_reg - nxt;
                left_next  = left_reg - nxt[16:0];
                state_next = ST_N2;
            end
            ST_N2: begin
                // net effect of the step: subtract the remaining time if high after it
                if (adv) begin
                    shift_next = ns;
                    cnt_next   = cnt_reg + CNT_W'(hp_reg[3]);
                end
                out_next[3] = o_new;
                v_next      = o_new ? (v_reg - cnt_reg) : v_reg;
                state_next  = ST_N1;
                if (left_reg == '0) begin
                    dc_next[3] = adv ? (cnt_reg + CNT_W'(hp_reg[3])) : cnt_reg;
                    hi_next[3] = HI_W'(o_new ? (v_reg - cnt_reg) : v_reg);
                    sl_next    = '0;
                    sr_next    = '0;
                    ch_next    = 2'd0;
                    state_next = ST_MIX_M;
                end
            end
            ST_MIX_M: begin
                mul_a      = MA_W'(hi_reg[ch_reg]);
                mul_b      = MB_W'(lvl_reg[ch_reg]);
                state_next = ST_MIX_A;
            end
            ST_MIX_A: begin
                if (stereo_reg[{1'b1, ch_reg}]) sl_next = sl_reg + SUM_W'(prod_reg);
                if (stereo_reg[{1'b0, ch_reg}]) sr_next = sr_reg + SUM_W'(prod_reg);
                ch_next    = ch_reg + 2'd1;
                state_next = (ch_reg == 2'd3) ? ST_G_L : ST_MIX_M;
            end
            ST_G_L: begin
                mul_a      = MA_W'({1'b0, lm});
                mul_b      = gain_reg;
                state_next = ST_G_LA;
            end
            ST_G_LA: begin
                gl_next    = rtl_reg ? gsat : '0;
                mul_a      = MA_W'({1'b0, rm});
                mul_b      = gain_reg;
                state_next = ST_G_RA;
            end
            ST_G_RA: begin
                // keep the right product live until the output register is free
                mul_a      = MA_W'({1'b0, rm});
                mul_b      = gain_reg;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                mul_a = MA_W'({1'b0, rm});
                mul_b = gain_reg;
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = {1'b0, (rtr_reg ? gsat : {MIX_W{1'b0}}), 1'b0, gl_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ch_reg      <= 2'd0;
            latch_reg   <= 3'd0;
            white_reg   <= 1'b0;
            shift_reg   <= RST_FBMASK;
            out_reg     <= {RST_FBMASK[0], 3'b000};
            stereo_reg  <= 8'hFF;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                tone_reg[i] <= i[0] ? 10'd15 : 10'd0;
            end
            for (int i = 0; i < 4; i++) begin
                lvl_reg[i] <= '0;
                hp_reg[i]  <= HP_W'(RST_STEP);
                dc_reg[i]  <= CNT_W'(RST_STEP);
            end
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            latch_reg   <= latch_next;
            white_reg   <= white_next;
            shift_reg   <= shift_next;
            out_reg     <= out_next;
            stereo_reg  <= stereo_next;
            m_valid_reg <= m_valid_next;
            tone_reg    <= tone_next;
            lvl_reg     <= lvl_next;
            hp_reg      <= hp_next;
            dc_reg      <= dc_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg      <= d_next;
        wr_r_reg   <= wr_r_next;
        hi_reg     <= hi_next;
        cnt_reg    <= cnt_next;
        v_reg      <= v_next;
        left_reg   <= left_next;
        sl_reg     <= sl_next;
        sr_reg     <= sr_next;
        gl_reg     <= gl_next;
        m_data_reg <= m_data_next;
    end

    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_axis_tuser == FUNC_TICK) |=> (state_reg == ST_T_INIT))
        else $error("tick did not start channel loop");

    a_counts_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (dc_reg[0] > 0 && dc_reg[1] > 0 &&
                                    dc_reg[2] > 0 && dc_reg[3] > 0))
        else $error("down count not positive between items");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output state");

    a_no_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_axis_tready) |=> (state_reg == ST_OUT))
        else $error("result overwritten while pending");

endmodule
`default_nettype wire

@@ test/psgtn_checker.sv @@
`default_nettype none
module psgtn_checker
    import psgtn_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               samples_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // configuration copy
    logic [19:0] step_cfg;
    logic [15:0] fb_mask, tap_mask, gain;
    logic        inv_white, left_on, right_on;

    // generator state
    logic [9:0]  period_reg [8];
    logic [2:0]  latch_sel;
    longint      atten_lvl  [4];
    logic [15:0] lfsr;
    logic        white;
    longint      half_per   [4];
    longint      remain     [4];
    logic [3:0]  level_hi;
    logic [7:0]  pan;
    longint      lvl_tab    [16];

    logic [31:0] sample_q [$];

    function automatic longint step_units();
        return (step_cfg == 0) ? 64'd1 : longint'(step_cfg);
    endfunction

    task automatic reset_generator();
        longint unsigned x;
        x = longint'(FULL / 4) << 16;
        for (int i = 0; i < 15; i++) begin
            lvl_tab[i] = longint'(x >> 16);
            x = (x * 64'd3411613790) >> 32;
        end
        lvl_tab[15] = 0;
        step_cfg  = RST_STEP;
        fb_mask   = RST_FBMASK;
        tap_mask  = RST_TAPS;
        inv_white = 1'b1;
        left_on   = 1'b1;
        right_on  = 1'b1;
        gain      = RST_GAIN;
        for (int i = 0; i < 8; i++) period_reg[i] = (i % 2) ? 10'd15 : 10'd0;
        latch_sel = '0;
        for (int i = 0; i < 4; i++) begin
            atten_lvl[i] = 0;
            half_per[i]  = step_units();
            remain[i]    = step_units();
        end
        lfsr     = fb_mask;
        white    = 1'b0;
        level_hi = {lfsr[0], 3'b000};
        pan      = 8'hFF;
        sample_q.delete();
    endtask

    function automatic void shift_noise();
        logic fb;
        fb = white ? ^(lfsr & tap_mask) : lfsr[0];
        lfsr = lfsr >> 1;
        if (fb) lfsr = lfsr | fb_mask;
        level_hi[3] = (white && inv_white) ? ~lfsr[0] : lfsr[0];
    endfunction

    function automatic longint tone_high(int i);
        longint v = 0;
        longint cnt = remain[i];
        longint per = half_per[i];
        if (level_hi[i]) v += cnt;
        cnt -= SPAN;
        while (cnt <= 0) begin
            cnt += per;
            if (cnt > 0) begin
                level_hi[i] = ~level_hi[i];
                if (level_hi[i]) v += per;
                break;
            end
            cnt += per;
            v += per;
        end
        if (level_hi[i]) v -= cnt;
        remain[i] = cnt;
        return v;
    endfunction

    function automatic longint noise_high();
        longint v = 0;
        longint cnt = remain[3];
        longint left = SPAN;
        longint nxt;
        do begin
            nxt = (cnt < left) ? cnt : left;
            if (level_hi[3]) v += cnt;
            cnt -= nxt;
            if (cnt <= 0) begin
                shift_noise();
                cnt += half_per[3];
                if (level_hi[3]) v += half_per[3];
            end
            if (level_hi[3]) v -= cnt;
            left -= nxt;
        end while (left > 0);
        remain[3] = cnt;
        return v;
    endfunction

    task automatic apply_write(logic [7:0] d);
        logic [2:0] r;
        int c;
        if (d[7]) begin
            r = d[6:4];
            latch_sel = r;
            period_reg[r][3:0] = d[3:0];
        end else begin
            r = latch_sel;
        end
        c = r >> 1;
        if (r == 0 || r == 2 || r == 4) begin
            if (!d[7]) period_reg[r][9:4] = d[5:0];
            half_per[c] = step_units() * longint'(period_reg[r]);
            if (half_per[c] == 0) half_per[c] = step_units();
            if (r == REG_TONE2 && period_reg[6][1:0] == 2'd3) half_per[3] = 2 * half_per[2];
        end else if (r == REG_NOISE) begin
            if (!d[7]) period_reg[6][3:0] = d[3:0];
            white = period_reg[6][2];
            if (period_reg[6][1:0] == 2'd3) half_per[3] = 2 * half_per[2];
            else half_per[3] = step_units() << (5 + period_reg[6][1:0]);
            lfsr = fb_mask;
            level_hi[3] = lfsr[0];
        end else begin
            atten_lvl[c] = lvl_tab[d[3:0]];
            if (!d[7]) period_reg[r][3:0] = d[3:0];
        end
    endtask

    function automatic longint mix(longint hi[4], logic [3:0] sel);
        longint s = 0;
        for (int i = 0; i < 4; i++)
            if (sel[i]) s += hi[i] * atten_lvl[i];
        if (s < 0) s = 0;
        if (s > longint'(FULL) * SPAN) s = longint'(FULL) * SPAN;
        return s / SPAN;
    endfunction

    function automatic logic [15:0] apply_gain(longint m, logic on);
        longint g;
        if (!on) return 16'd0;
        g = (m * longint'(gain)) >> 8;
        if (g > 32767) g = 32767;
        return g[15:0];
    endfunction

    task automatic predict_sample();
        longint hi[4];
        logic [15:0] l, r;
        for (int i = 0; i < 3; i++) hi[i] = tone_high(i);
        hi[3] = noise_high();
        l = apply_gain(mix(hi, pan[7:4]), left_on);
        r = apply_gain(mix(hi, pan[3:0]), right_on);
        sample_q.push_back({r, l});
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial begin
        errors = 0;
        samples_checked = 0;
        reset_generator();
    end

    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            reset_generator();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sample_q.size() == 0) begin
                    $display("[%0t] sample %h with none predicted", $realtime, m_axis_tdata);
                    errors++;
                end else begin
                    want = sample_q.pop_front();
                    samples_checked++;
                    if (m_axis_tdata[15:0] !== want[15:0])
                        report_mismatch("left_sample", $signed(m_axis_tdata[15:0]),
                                        $signed(want[15:0]));
                    if (m_axis_tdata[31:16] !== want[31:16])
                        report_mismatch("right_sample", $signed(m_axis_tdata[31:16]),
                                        $signed(want[31:16]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_UPDATE_STEP:   step_cfg  = cfg_data;
                    CFG_FEEDBACK_MASK: fb_mask   = cfg_data[15:0];
                    CFG_NOISE_TAPS:    tap_mask  = cfg_data[15:0];
                    CFG_NOISE_INVERT:  inv_white = cfg_data[0];
                    CFG_ROUTE_LEFT:    left_on   = cfg_data[0];
                    CFG_ROUTE_RIGHT:   right_on  = cfg_data[0];
                    CFG_OUT_GAIN:      gain      = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    FUNC_WRITE:  apply_write(s_axis_tdata);
                    FUNC_STEREO: pan = s_axis_tdata;
                    FUNC_TICK:   predict_sample();
                    default: ;
                endcase
            end
        end
        pending = sample_q.size();
    end
endmodule
`default_nettype wire

@@ test/tb_psg_tone_noise_generator_core.sv @@
`default_nettype none
module tb_psg_tone_noise_generator_core;
    import psgtn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;

    int errors, pending, samples_checked;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit hold_off = 1'b0;
    logic [2:0] cur_latch = '0;

    always #2 aclk = ~aclk;

    psg_tone_noise_generator_core dut (.*);

    psgtn_checker chk (
        .aclk, .aresetn,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending, .samples_checked
    );

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("psg_tone_noise_generator_core: mismatch");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] func, logic [7:0] d);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        if (func == FUNC_WRITE && d[7]) cur_latch = d[6:4];
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic end_config();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // drain all predicted samples, then let trailing byte writes finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // latch/data pairs with random content; tone periods left alone when the
    // step is tiny, since a short half period makes ticks very slow
    task automatic random_items(int n, bit tone_ok);
        int kind;
        logic [2:0] r;
        logic [7:0] d;
        for (int k = 0; k < n; k++) begin
            kind = $urandom_range(0, 9);
            d = $urandom_range(0, 255);
            if (kind <= 3) begin
                send_item(FUNC_TICK, d);
            end else if (kind <= 6) begin
                r = $urandom_range(0, 7);
                if (!tone_ok && r[0] == 1'b0 && r != REG_NOISE) r = r + 3'd1;
                send_item(FUNC_WRITE, {1'b1, r, d[3:0]});
                if ($urandom_range(0, 1)) send_item(FUNC_WRITE, {1'b0, d[7:1]});
            end else if (kind == 7) begin
                if (tone_ok || cur_latch[0] || cur_latch == REG_NOISE)
                    send_item(FUNC_WRITE, {1'b0, d[6:0]});
                else
                    send_item(FUNC_TICK, d);
            end else if (kind == 8) begin
                send_item(FUNC_STEREO, d);
            end else begin
                send_item(2'd3, d);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: period extremes, attenuation ends, noise modes, pan, func 3
        send_item(FUNC_WRITE, 8'h8F);   send_item(FUNC_WRITE, 8'h3F);
        send_item(FUNC_WRITE, 8'h90);
        send_item(FUNC_WRITE, 8'hA1);   send_item(FUNC_WRITE, 8'h00);
        send_item(FUNC_WRITE, 8'hB5);
        send_item(FUNC_WRITE, 8'hC0);   send_item(FUNC_WRITE, 8'h40);
        send_item(FUNC_WRITE, 8'hDF);
        send_item(FUNC_WRITE, 8'hE7);   send_item(FUNC_WRITE, 8'hF0);
        send_item(FUNC_STEREO, 8'hFF);  send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_STEREO, 8'hA5);  send_item(FUNC_TICK, 8'hFF);
        send_item(2'd3, 8'h55);         send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_WRITE, 8'h03);
        send_item(FUNC_WRITE, 8'hE4);   send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_WRITE, 8'hE0);   send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_STEREO, 8'h00);  send_item(FUNC_TICK, 8'h00);
        send_item(FUNC_STEREO, 8'hFF);

        hold_off = 1'b1;
        random_items(200, 1'b1);
        drain();

        write_reg(CFG_UPDATE_STEP, 20'hFFFFF);
        write_reg(CFG_FEEDBACK_MASK, 20'hFFFF);
        write_reg(CFG_NOISE_TAPS, 20'hFFFF);
        write_reg(CFG_NOISE_INVERT, 20'd0);
        write_reg(CFG_ROUTE_LEFT, 20'd0);
        write_reg(CFG_ROUTE_RIGHT, 20'd1);
        write_reg(CFG_OUT_GAIN, 20'hFFFF);
        end_config();
        random_items(150, 1'b1);
        drain();

        write_reg(CFG_UPDATE_STEP, 20'd1);
        write_reg(CFG_FEEDBACK_MASK, 20'd1);
        write_reg(CFG_NOISE_TAPS, 20'd0);
        write_reg(CFG_NOISE_INVERT, 20'd1);
        write_reg(CFG_ROUTE_LEFT, 20'd1);
        write_reg(CFG_ROUTE_RIGHT, 20'd0);
        write_reg(CFG_OUT_GAIN, 20'd0);
        end_config();
        // long tone periods first so ticks stay short at a step of one
        for (int t = 0; t < 3; t++) begin
            send_item(FUNC_WRITE, {1'b1, 3'(2 * t), 4'hF});
            send_item(FUNC_WRITE, 8'h3F);
        end
        random_items(70, 1'b0);
        drain();
        write_reg(CFG_OUT_GAIN, 20'd256);
        write_reg(CFG_ROUTE_RIGHT, 20'd1);
        end_config();
        random_items(70, 1'b0);
        drain();

        // step of zero behaves as one; tail runs without idling
        write_reg(CFG_UPDATE_STEP, 20'd0);
        write_reg(CFG_FEEDBACK_MASK, 20'($urandom_range(1, 65535)));
        write_reg(CFG_NOISE_TAPS, 20'($urandom_range(0, 65535)));
        write_reg(CFG_OUT_GAIN, 20'($urandom_range(128, 1024)));
        end_config();
        random_items(60, 1'b0);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_items(80, 1'b0);
        drain();

        $display("sent %0d items, checked %0d stereo samples across default, maximum,",
                 items_sent, samples_checked);
        $display("unit and zero update steps with varied noise, routing and gain settings");
        if (errors == 0)
            $display("psg_tone_noise_generator_core: match");
        else
            $display("psg_tone_noise_generator_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

@@ psg_tone_noise_generator_core.f @@
sv/psgtn_pkg.sv
sv/psgtn_mul.sv
sv/psg_tone_noise_generator_core.sv
test/psgtn_checker.sv
test/tb_psg_tone_noise_generator_core.sv
